// ===== rtl/core/wcs_pkg.sv =====
`default_nettype none

package wcs_pkg;

    localparam int unsigned PhaseW = 4;
    localparam int unsigned CountW = 12;
    localparam int unsigned ModeW  = 2;
    localparam int unsigned UnitW  = 4;
    localparam int unsigned AddrW  = 3;
    localparam int unsigned DataW  = 4;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    // cycle phases
    localparam logic [PhaseW-1:0] PH_IDLE    = 4'd0;
    localparam logic [PhaseW-1:0] PH_PREGAS  = 4'd1;
    localparam logic [PhaseW-1:0] PH_IGNITE  = 4'd2;
    localparam logic [PhaseW-1:0] PH_2T      = 4'd3;
    localparam logic [PhaseW-1:0] PH_4TA     = 4'd4;
    localparam logic [PhaseW-1:0] PH_4TB     = 4'd5;
    localparam logic [PhaseW-1:0] PH_CPULSE  = 4'd6;
    localparam logic [PhaseW-1:0] PH_CPAUSE  = 4'd7;
    localparam logic [PhaseW-1:0] PH_TACK    = 4'd8;
    localparam logic [PhaseW-1:0] PH_POSTGAS = 4'd9;
    localparam logic [PhaseW-1:0] PH_WAITREL = 4'd10;

    // weld modes
    localparam logic [ModeW-1:0] MODE_2T    = 2'd0;
    localparam logic [ModeW-1:0] MODE_4T    = 2'd1;
    localparam logic [ModeW-1:0] MODE_COLD  = 2'd2;
    localparam logic [ModeW-1:0] MODE_TACK  = 2'd3;

    // register indexes
    localparam logic [AddrW-1:0] REG_MODE     = 3'd0;
    localparam logic [AddrW-1:0] REG_PRE_GAS  = 3'd1;
    localparam logic [AddrW-1:0] REG_POST_GAS = 3'd2;
    localparam logic [AddrW-1:0] REG_ARC      = 3'd3;
    localparam logic [AddrW-1:0] REG_PULSE    = 3'd4;

    // register reset values
    localparam logic [ModeW-1:0] RST_MODE     = MODE_2T;
    localparam logic [UnitW-1:0] RST_PRE_GAS  = 4'd2;
    localparam logic [UnitW-1:0] RST_POST_GAS = 4'd5;
    localparam logic [UnitW-1:0] RST_ARC      = 4'd2;
    localparam logic [UnitW-1:0] RST_PULSE    = 4'd2;

    // milliseconds per unit
    localparam int unsigned MsW = 9;
    localparam logic [MsW-1:0] MS_PRE_GAS  = 9'd250;
    localparam logic [MsW-1:0] MS_POST_GAS = 9'd375;
    localparam logic [MsW-1:0] MS_IGNITE   = 9'd100;
    localparam logic [MsW-1:0] MS_TACK     = 9'd100;
    localparam logic [MsW-1:0] MS_CPULSE   = 9'd10;
    localparam logic [MsW-1:0] MS_CPAUSE   = 9'd50;

    typedef struct packed {
        logic [ModeW-1:0] weld_mode;
        logic [UnitW-1:0] pre_gas_units;
        logic [UnitW-1:0] post_gas_units;
        logic [UnitW-1:0] arc_units;
        logic [UnitW-1:0] pulse_units;
    } cfg_t;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic [CountW-1:0] countdown;
        logic              gas;
        logic              power;
        logic              starter;
    } seq_state_t;

    // units times a fixed step, clamped to the countdown range
    function automatic logic [CountW-1:0] load_time(input logic [UnitW-1:0] units,
                                                    input logic [MsW-1:0] ms_per_unit);
        logic [UnitW+MsW-1:0] prod;
        prod = units * ms_per_unit;
        if (prod > (UnitW+MsW)'(CountMax)) begin
            return CountMax;
        end
        return prod[CountW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wcs_step.sv =====
`default_nettype none

module wcs_step (
    input  wire wcs_pkg::seq_state_t cur,
    input  wire wcs_pkg::cfg_t       cfg,
    input  wire logic                trigger_held,
    input  wire logic                menu_active,
    input  wire logic                purge_request,
    output wcs_pkg::seq_state_t      nxt
);

    logic [wcs_pkg::CountW-1:0] cnt_dec;
    logic                       expired;
    logic [wcs_pkg::CountW-1:0] post_load;

    assign cnt_dec   = cur.countdown - {{(wcs_pkg::CountW-1){1'b0}}, |cur.countdown};
    assign expired   = (cnt_dec == '0);
    assign post_load = wcs_pkg::load_time(cfg.post_gas_units, wcs_pkg::MS_POST_GAS);

    always_comb begin
        nxt           = cur;
        nxt.countdown = cnt_dec;
        unique case (cur.phase)
            wcs_pkg::PH_IDLE: begin
                nxt.power   = 1'b0;
                nxt.starter = 1'b0;
                if (trigger_held && !menu_active) begin
                    nxt.gas       = 1'b1;
                    nxt.countdown = wcs_pkg::load_time(cfg.pre_gas_units,
                                                       wcs_pkg::MS_PRE_GAS);
                    nxt.phase     = wcs_pkg::PH_PREGAS;
                end else begin
                    nxt.gas = purge_request && !menu_active;
                end
            end
            wcs_pkg::PH_PREGAS: begin
                if (expired) begin
                    nxt.power   = 1'b1;
                    nxt.starter = 1'b1;
                    if (cfg.weld_mode == wcs_pkg::MODE_COLD) begin
                        nxt.countdown = wcs_pkg::load_time(cfg.arc_units, wcs_pkg::MS_CPULSE);
                        nxt.phase     = wcs_pkg::PH_CPULSE;
                    end else if (cfg.weld_mode == wcs_pkg::MODE_TACK) begin
                        nxt.countdown = wcs_pkg::load_time(cfg.pulse_units, wcs_pkg::MS_TACK);
                        nxt.phase     = wcs_pkg::PH_TACK;
                    end else begin
                        nxt.countdown = wcs_pkg::load_time(cfg.arc_units, wcs_pkg::MS_IGNITE);
                        nxt.phase     = wcs_pkg::PH_IGNITE;
                    end
                end
            end
            wcs_pkg::PH_IGNITE: begin
                if (expired) begin
                    nxt.starter = 1'b0;
                    nxt.phase   = (cfg.weld_mode == wcs_pkg::MODE_2T) ?
                                  wcs_pkg::PH_2T : wcs_pkg::PH_4TA;
                end
            end
            wcs_pkg::PH_2T: begin
                if (!trigger_held) begin
                    nxt.power     = 1'b0;
                    nxt.starter   = 1'b0;
                    nxt.countdown = post_load;
                    nxt.phase     = wcs_pkg::PH_POSTGAS;
                end
            end
            wcs_pkg::PH_4TA: begin
                if (!trigger_held) begin
                    nxt.phase = wcs_pkg::PH_4TB;
                end
            end
            wcs_pkg::PH_4TB: begin
                if (trigger_held) begin
                    nxt.power     = 1'b0;
                    nxt.starter   = 1'b0;
                    nxt.countdown = post_load;
                    nxt.phase     = wcs_pkg::PH_POSTGAS;
                end
            end
            wcs_pkg::PH_CPULSE: begin
                if (!trigger_held) begin
                    nxt.power     = 1'b0;
                    nxt.starter   = 1'b0;
                    nxt.countdown = post_load;
                    nxt.phase     = wcs_pkg::PH_POSTGAS;
                end else if (expired) begin
                    nxt.power     = 1'b0;
                    nxt.starter   = 1'b0;
                    nxt.countdown = wcs_pkg::load_time(cfg.pulse_units, wcs_pkg::MS_CPAUSE);
                    nxt.phase     = wcs_pkg::PH_CPAUSE;
                end
            end
            wcs_pkg::PH_CPAUSE: begin
                if (!trigger_held) begin
                    nxt.power     = 1'b0;
                    nxt.starter   = 1'b0;
                    nxt.countdown = post_load;
                    nxt.phase     = wcs_pkg::PH_POSTGAS;
                end else if (expired) begin
                    nxt.power     = 1'b1;
                    nxt.starter   = 1'b1;
                    nxt.countdown = wcs_pkg::load_time(cfg.arc_units, wcs_pkg::MS_CPULSE);
                    nxt.phase     = wcs_pkg::PH_CPULSE;
                end
            end
            wcs_pkg::PH_TACK: begin
                if (expired) begin
                    nxt.power     = 1'b0;
                    nxt.starter   = 1'b0;
                    nxt.countdown = post_load;
                    nxt.phase     = wcs_pkg::PH_POSTGAS;
                end
            end
            wcs_pkg::PH_POSTGAS: begin
                nxt.gas     = 1'b1;
                nxt.power   = 1'b0;
                nxt.starter = 1'b0;
                if (expired) begin
                    nxt.gas   = 1'b0;
                    nxt.phase = wcs_pkg::PH_WAITREL;
                end
            end
            wcs_pkg::PH_WAITREL: begin
                if (!trigger_held) begin
                    nxt.phase = wcs_pkg::PH_IDLE;
                end
            end
            default: begin
                // unused code: drop back to idle with everything off
                nxt.gas     = 1'b0;
                nxt.power   = 1'b0;
                nxt.starter = 1'b0;
                nxt.phase   = wcs_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/wcs_cfg_regs.sv =====
`default_nettype none

module wcs_cfg_regs (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [wcs_pkg::AddrW-1:0] cfg_addr,
    input  wire logic [wcs_pkg::DataW-1:0] cfg_wdata,
    output wcs_pkg::cfg_t                  cfg
);

    wcs_pkg::cfg_t cfg_reg;
    wcs_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                wcs_pkg::REG_MODE:     cfg_next.weld_mode      = cfg_wdata[wcs_pkg::ModeW-1:0];
                wcs_pkg::REG_PRE_GAS:  cfg_next.pre_gas_units  = cfg_wdata;
                wcs_pkg::REG_POST_GAS: cfg_next.post_gas_units = cfg_wdata;
                wcs_pkg::REG_ARC:      cfg_next.arc_units      = cfg_wdata;
                wcs_pkg::REG_PULSE:    cfg_next.pulse_units    = cfg_wdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.weld_mode      <= wcs_pkg::RST_MODE;
            cfg_reg.pre_gas_units  <= wcs_pkg::RST_PRE_GAS;
            cfg_reg.post_gas_units <= wcs_pkg::RST_POST_GAS;
            cfg_reg.arc_units      <= wcs_pkg::RST_ARC;
            cfg_reg.pulse_units    <= wcs_pkg::RST_PULSE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/weld_cycle_sequencer_core.sv =====
// A result beat is presented the cycle after its tick is accepted.
// Throughput: one tick per clock; the single-pass step logic between the
// state register and the result register sets this, stalling only while a
// held result is not taken.
// Reset (aresetn low at a clock edge): phase idle, countdown zero, all
// enables off, registers to defaults, result register empty.
`default_nettype none

module weld_cycle_sequencer_core (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_trigger_held,
    input  wire logic                      s_menu_active,
    input  wire logic                      s_purge_request,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_gas_on,
    output logic                           m_power_on,
    output logic                           m_starter_on,
    output logic [wcs_pkg::PhaseW-1:0]     m_phase,
    input  wire logic                      cfg_we,
    input  wire logic [wcs_pkg::AddrW-1:0] cfg_addr,
    input  wire logic [wcs_pkg::DataW-1:0] cfg_wdata
);

    wcs_pkg::cfg_t       cfg;
    wcs_pkg::seq_state_t state_reg;
    wcs_pkg::seq_state_t state_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic                s_beat;

    wcs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    wcs_step u_step (
        .cur           (state_reg),
        .cfg           (cfg),
        .trigger_held  (s_trigger_held),
        .menu_active   (s_menu_active),
        .purge_request (s_purge_request),
        .nxt           (state_next)
    );

    // take a new tick whenever the result slot is empty or being emptied
    assign s_ready = !m_valid_reg || m_ready;
    assign s_beat  = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_beat) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase     <= wcs_pkg::PH_IDLE;
            state_reg.countdown <= '0;
            state_reg.gas       <= 1'b0;
            state_reg.power     <= 1'b0;
            state_reg.starter   <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_beat) begin
                state_reg <= state_next;
            end
        end
    end

    // the state after each tick is the result beat itself
    assign m_valid      = m_valid_reg;
    assign m_gas_on     = state_reg.gas;
    assign m_power_on   = state_reg.power;
    assign m_starter_on = state_reg.starter;
    assign m_phase      = state_reg.phase;

endmodule

`default_nettype wire

// ===== rtl/core/wcs_checker.sv =====
`default_nettype none

module wcs_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic                      m_gas_on,
    input wire logic                      m_power_on,
    input wire logic                      m_starter_on,
    input wire logic [wcs_pkg::PhaseW-1:0] m_phase
);

    // every accepted tick yields a result beat on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("tick accepted without a following result beat");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_phase) && $stable(m_gas_on))
        else $error("stalled result beat changed");

    // current only flows under gas
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_power_on |-> m_gas_on)
        else $error("power on without gas");

    // starter only fires with power in a striking phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_starter_on |-> m_power_on &&
            (m_phase == wcs_pkg::PH_IGNITE || m_phase == wcs_pkg::PH_CPULSE ||
             m_phase == wcs_pkg::PH_TACK))
        else $error("starter on outside a striking phase");

    // idle, post-gas and wait-release never carry power
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_phase == wcs_pkg::PH_IDLE || m_phase == wcs_pkg::PH_WAITREL ||
                    m_phase == wcs_pkg::PH_POSTGAS) |-> !m_power_on)
        else $error("power on in a non-welding phase");

endmodule

bind weld_cycle_sequencer_core wcs_checker u_wcs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_gas_on     (m_gas_on),
    .m_power_on   (m_power_on),
    .m_starter_on (m_starter_on),
    .m_phase      (m_phase)
);

`default_nettype wire
